// ----- sv/cpr_pkg.sv -----
// shared constants and types for the clock page replacement block
package cpr_pkg;

  localparam int DEF_PROCESSES = 16;
  localparam int DEF_FRAMES    = 16;

  localparam int PID_W    = 4;
  localparam int SLOT_W   = 4;
  localparam int FPP_W    = 5;
  localparam int IN_DW    = 16;
  localparam int OUT_DW   = 8;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  // replacement modes
  localparam logic CLOCK   = 1'b0;
  localparam logic CLOCK_M = 1'b1;

  // register index, taken from paddr bit 2
  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_FRAMES = 1'b1;

  localparam logic [FPP_W-1:0] FPP_RESET = 5'd16;

  typedef enum logic [1:0] {
    MOD_ZERO,
    MOD_ONE,
    MOD_ANY
  } mod_sel_t;

  typedef struct packed {
    logic clr_en;
    logic accept;
    logic mod_step;
    logic scan_init;
    logic scan_run;
    logic out_load;
  } cpr_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic scan_req;
    logic mod_done;
    logic hit;
    logic miss_done;
    logic out_free;
  } cpr_stat_t;

endpackage

// ----- sv/cpr_ctrl.sv -----
// controller state machine for the clock page replacement block
module cpr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  cpr_pkg::cpr_stat_t stat,
  output cpr_pkg::cpr_cmd_t  cmd
);
  import cpr_pkg::*;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_MOD,
    S_INIT,
    S_SCAN,
    S_RES
  } state_t;

  state_t state_r;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.clr_en    = (state_r == S_CLR);
    cmd.accept    = (state_r == S_IDLE) && in_tvalid;
    cmd.mod_step  = (state_r == S_MOD);
    cmd.scan_init = (state_r == S_INIT);
    cmd.scan_run  = (state_r == S_SCAN);
    cmd.out_load  = (state_r == S_RES) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      unique case (state_r)
        S_CLR: begin
          if (stat.clr_done) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid) state_r <= stat.scan_req ? S_MOD : S_RES;
        end
        S_MOD: begin
          if (stat.mod_done) state_r <= S_INIT;
        end
        S_INIT: begin
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (stat.hit || stat.miss_done) state_r <= S_RES;
        end
        S_RES: begin
          if (stat.out_free) state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_CLR;
        end
      endcase
    end
  end

endmodule

// ----- sv/cpr_dp.sv -----
// datapath: flag memory, hand memory, hand remainder, slot scan and output register
module cpr_dp #(
  parameter int PROCESSES = cpr_pkg::DEF_PROCESSES,
  parameter int FRAMES    = cpr_pkg::DEF_FRAMES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cpr_pkg::cpr_cmd_t          cmd,
  output cpr_pkg::cpr_stat_t         stat,
  input  logic [cpr_pkg::IN_DW-1:0]  in_tdata,
  input  logic                       in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [cpr_pkg::OUT_DW-1:0] out_tdata,
  output logic                       out_tuser,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [cpr_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [cpr_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [cpr_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import cpr_pkg::*;

  localparam int DEPTH = PROCESSES * FRAMES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int HW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int HCW   = (HW > 1) ? $clog2(HW) : 1;

  typedef struct packed {
    logic present;
    logic dirty;
    logic used;
  } entry_t;

  // configuration
  logic             mode_r;
  logic [FPP_W-1:0] fpp_r;
  logic [FPP_W-1:0] n_c;

  // input fields
  logic [PID_W-1:0]  in_pid;
  logic [SLOT_W-1:0] in_slot;
  logic              pid_ok;
  logic              slot_ok;
  logic              upd_ok;

  // memories
  entry_t        mem [DEPTH];
  logic [HW-1:0] hands [PROCESSES];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  entry_t        mem_wd;
  logic          mem_re;
  logic [AW-1:0] rd_addr_c;
  logic [AW-1:0] upd_addr_c;
  entry_t        rd_data_r;
  logic [HW-1:0] hand_rd_r;
  logic [AW-1:0] clr_cnt_r;
  logic          clr_hand_c;

  // hand remainder
  logic [PW-1:0]    pid_r;
  logic [FPP_W-1:0] rem_r;
  logic [FPP_W-1:0] rem_nxt;
  logic [FPP_W:0]   rem_sh_c;
  logic [HCW-1:0]   mod_cnt_r;

  // scan
  logic             issuing_r;
  logic [FPP_W-1:0] rd_slot_r;
  logic [FPP_W-1:0] rd_k_r;
  logic [1:0]       rd_round_r;
  logic             rd_k_last_c;
  logic             rd_last_c;
  logic [1:0]       last_round_c;
  logic             ev_valid_r;
  logic [FPP_W-1:0] ev_slot_r;
  logic [AW-1:0]    ev_addr_r;
  logic [1:0]       ev_round_r;
  logic             ev_last_r;
  mod_sel_t         mod_sel_c;
  logic             clear_c;
  logic             mod_ok_c;
  logic             hit_c;

  // result
  logic [SLOT_W-1:0] res_slot_r;
  logic              res_found_r;
  logic              out_valid_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_found_r;

  assign in_pid  = in_tdata[PID_W-1:0];
  assign in_slot = in_tdata[PID_W+SLOT_W-1:PID_W];
  assign pid_ok  = int'(in_pid) < PROCESSES;
  assign slot_ok = int'(in_slot) < FRAMES;
  assign upd_ok  = !in_tuser && pid_ok && slot_ok;

  assign n_c = (int'(fpp_r) > FRAMES) ? FPP_W'(FRAMES) : fpp_r;

  assign rd_addr_c  = AW'(pid_r) * AW'(FRAMES) + AW'(rd_slot_r);
  assign upd_addr_c = AW'(in_pid) * AW'(FRAMES) + AW'(in_slot);

  // remainder of the stored hand by the slot count, one bit a step
  assign rem_sh_c = {rem_r, hand_rd_r[mod_cnt_r]};
  assign rem_nxt  = (rem_sh_c >= {1'b0, n_c}) ? FPP_W'(rem_sh_c - {1'b0, n_c})
                                             : FPP_W'(rem_sh_c);

  assign last_round_c = (mode_r == CLOCK_M) ? 2'd3 : 2'd1;
  assign rd_k_last_c  = (rd_k_r == n_c - 1'b1);
  assign rd_last_c    = rd_k_last_c && (rd_round_r == last_round_c);

  always_comb begin
    mod_sel_c = MOD_ANY;
    clear_c   = 1'b1;
    if (mode_r == CLOCK_M) begin
      unique case (ev_round_r)
        2'd0: begin
          mod_sel_c = MOD_ZERO;
          clear_c   = 1'b0;
        end
        2'd1: mod_sel_c = MOD_ONE;
        2'd2: mod_sel_c = MOD_ANY;
        2'd3: mod_sel_c = MOD_ONE;
      endcase
    end
  end

  always_comb begin
    case (mod_sel_c)
      MOD_ZERO: mod_ok_c = !rd_data_r.dirty;
      MOD_ONE:  mod_ok_c = rd_data_r.dirty;
      default:  mod_ok_c = 1'b1;
    endcase
  end

  assign hit_c = ev_valid_r && rd_data_r.present && !rd_data_r.used && mod_ok_c;

  // flag memory write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_cnt_r;
    mem_wd = '0;
    priority if (cmd.clr_en) begin
      mem_we = 1'b1;
    end else if (cmd.accept && upd_ok) begin
      mem_we = 1'b1;
      mem_wa = upd_addr_c;
      mem_wd = '{present: in_tdata[PID_W+SLOT_W+2],
                 dirty:   in_tdata[PID_W+SLOT_W+1],
                 used:    in_tdata[PID_W+SLOT_W]};
    end else if (cmd.scan_run && ev_valid_r && !hit_c && clear_c) begin
      mem_we = 1'b1;
      mem_wa = ev_addr_r;
      mem_wd = '{present: rd_data_r.present, dirty: rd_data_r.dirty, used: 1'b0};
    end
  end

  assign mem_re     = cmd.scan_run && issuing_r;
  assign clr_hand_c = cmd.clr_en && (int'(clr_cnt_r) < PROCESSES);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) begin
      rd_data_r <= (mem_we && (mem_wa == rd_addr_c)) ? mem_wd : mem[rd_addr_c];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_hand_c) begin
      hands[clr_cnt_r[PW-1:0]] <= '0;
    end else if (cmd.scan_run && hit_c) begin
      hands[pid_r] <= HW'(ev_slot_r);
    end
    if (cmd.accept) hand_rd_r <= hands[PW'(in_pid)];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      issuing_r   <= 1'b0;
      ev_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= CLOCK;
      fpp_r       <= FPP_RESET;
    end else begin
      if (cmd.clr_en) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        unique case (cfg_paddr[2])
          REG_MODE:   mode_r <= cfg_pwdata[0];
          REG_FRAMES: fpp_r  <= cfg_pwdata[FPP_W-1:0];
        endcase
      end
      if (cmd.scan_init) begin
        issuing_r  <= 1'b1;
        ev_valid_r <= 1'b0;
      end else if (cmd.scan_run) begin
        ev_valid_r <= issuing_r;
        if (issuing_r && rd_last_c) issuing_r <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pid_r       <= PW'(in_pid);
      res_slot_r  <= '0;
      res_found_r <= 1'b0;
      rem_r       <= '0;
      mod_cnt_r   <= HCW'(HW - 1);
    end
    if (cmd.mod_step) begin
      rem_r     <= rem_nxt;
      mod_cnt_r <= mod_cnt_r - 1'b1;
    end
    if (cmd.scan_init) begin
      rd_slot_r  <= rem_r;
      rd_k_r     <= '0;
      rd_round_r <= '0;
    end else if (mem_re) begin
      ev_slot_r  <= rd_slot_r;
      ev_addr_r  <= rd_addr_c;
      ev_round_r <= rd_round_r;
      ev_last_r  <= rd_last_c;
      if (rd_k_last_c) begin
        rd_k_r     <= '0;
        rd_slot_r  <= rem_r;
        rd_round_r <= rd_round_r + 1'b1;
      end else begin
        rd_k_r    <= rd_k_r + 1'b1;
        rd_slot_r <= (rd_slot_r == n_c - 1'b1) ? '0 : rd_slot_r + 1'b1;
      end
    end
    if (cmd.scan_run && hit_c) begin
      res_slot_r  <= SLOT_W'(ev_slot_r);
      res_found_r <= 1'b1;
    end
    if (cmd.out_load) begin
      out_slot_r  <= res_slot_r;
      out_found_r <= res_found_r;
    end
  end

  always_comb begin
    stat           = '0;
    stat.clr_done  = (clr_cnt_r == AW'(DEPTH - 1));
    stat.scan_req  = in_tuser && pid_ok && (n_c != '0);
    stat.mod_done  = (mod_cnt_r == '0);
    stat.hit       = hit_c;
    stat.miss_done = ev_valid_r && ev_last_r && !hit_c;
    stat.out_free  = !out_valid_r || out_tready;
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_MODE:   cfg_prdata = CFG_DW'(mode_r);
      REG_FRAMES: cfg_prdata = CFG_DW'(fpp_r);
    endcase
  end

  assign cfg_pready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'(out_slot_r);
  assign out_tuser  = out_found_r;

endmodule

// ----- sv/clock_page_replacement.sv -----
// top level of the per-process clock page replacement block
//
//  channel | direction | handshake              | payload
//  in_     | slave     | in_tvalid/in_tready    | tuser: command; tdata: process_id, slot_index,
//          |           |                        |   use_bit, modified_bit, present_bit
//  out_    | master    | out_tvalid/out_tready  | tdata: victim_slot; tuser: victim_found
//  cfg_    | apb slave | psel/penable/pready    | replacement_mode at 0x0, frames_per_process at 0x4
//
// an update or a rejected request goes from accept straight to the result state, with no victim
// a victim request reduces the hand by the slot count n, then scans up to passes*n slots,
// passes 2 in plain clock and 4 in enhanced; one slot is read from the flag memory per cycle
// after reset the flag and hand memories are swept with in_tready low
// a held result does not stop the next item from being taken; work stalls only before loading it
module clock_page_replacement #(
  parameter int PROCESSES = cpr_pkg::DEF_PROCESSES,
  parameter int FRAMES    = cpr_pkg::DEF_FRAMES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // [3:0] process_id, [7:4] slot_index, [8] use_bit, [9] modified_bit, [10] present_bit
  input  logic [cpr_pkg::IN_DW-1:0]  in_tdata,
  // [0] command
  input  logic                       in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [3:0] victim_slot
  output logic [cpr_pkg::OUT_DW-1:0] out_tdata,
  // [0] victim_found
  output logic                       out_tuser,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [cpr_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [cpr_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [cpr_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import cpr_pkg::*;

  cpr_cmd_t  cmd;
  cpr_stat_t stat;

  cpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cpr_dp #(
    .PROCESSES (PROCESSES),
    .FRAMES    (FRAMES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

endmodule

// ----- sv/cpr_checker.sv -----
// port checker for the clock page replacement block, with its bind
module cpr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [cpr_pkg::OUT_DW-1:0] out_tdata,
  input logic                       out_tuser
);
  import cpr_pkg::*;

  // memory sweep after reset keeps both sides quiet
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("item moved right after reset");

  // no victim means slot zero
  a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("slot nonzero without a victim");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind clock_page_replacement cpr_checker u_cpr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- test/testbench.sv -----
// testbench for clock_page_replacement: table-driven and random page commands, self-checking
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cpr_pkg::*;

  localparam int NPROC = DEF_PROCESSES;
  localparam int NFRM = DEF_FRAMES;
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_VICTIM = 1'b1;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam int TABLE_LEN = 19;

  typedef struct packed {
    logic              cmd;
    logic [PID_W-1:0]  pid;
    logic [SLOT_W-1:0] slot;
    logic              use_b;
    logic              mod_b;
    logic              pres_b;
  } page_op_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              found;
  } victim_t;

  typedef struct packed {
    page_op_t op;
    logic     typed;
    victim_t  want;
  } op_row_t;

  localparam victim_t NONE = '{slot: '0, found: 1'b0};

  localparam op_row_t OP_TABLE [TABLE_LEN] = '{
    '{'{CMD_VICTIM, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b1, NONE},
    '{'{CMD_VICTIM, 4'd15, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b1, NONE},
    '{'{CMD_UPDATE, 4'd15, 4'd15, 1'b1, 1'b1, 1'b1}, 1'b1, NONE},
    '{'{CMD_UPDATE, 4'd0, 4'd0, 1'b0, 1'b0, 1'b1}, 1'b1, NONE},
    '{'{CMD_VICTIM, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b1, '{slot: 4'd0, found: 1'b1}},
    '{'{CMD_VICTIM, 4'd15, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b0, NONE},
    '{'{CMD_VICTIM, 4'd15, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b0, NONE},
    '{'{CMD_UPDATE, 4'd3, 4'd0, 1'b1, 1'b0, 1'b1}, 1'b1, NONE},
    '{'{CMD_UPDATE, 4'd3, 4'd1, 1'b1, 1'b1, 1'b1}, 1'b1, NONE},
    '{'{CMD_UPDATE, 4'd3, 4'd2, 1'b0, 1'b1, 1'b1}, 1'b1, NONE},
    '{'{CMD_UPDATE, 4'd3, 4'd3, 1'b0, 1'b0, 1'b0}, 1'b1, NONE},
    '{'{CMD_UPDATE, 4'd3, 4'd15, 1'b0, 1'b0, 1'b1}, 1'b1, NONE},
    '{'{CMD_VICTIM, 4'd3, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b0, NONE},
    '{'{CMD_VICTIM, 4'd3, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b0, NONE},
    '{'{CMD_VICTIM, 4'd3, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b0, NONE},
    '{'{CMD_UPDATE, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b1, NONE},
    '{'{CMD_VICTIM, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b1, NONE},
    '{'{CMD_UPDATE, 4'd7, 4'd9, 1'b1, 1'b1, 1'b0}, 1'b1, NONE},
    '{'{CMD_VICTIM, 4'd7, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b1, NONE}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic              out_tuser;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  clock_page_replacement dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the page flags, hands and registers
  bit               use_f   [NPROC*NFRM];
  bit               dirty_f [NPROC*NFRM];
  bit               res_f   [NPROC*NFRM];
  int               hands   [NPROC];
  logic             mode_reg = CLOCK;
  logic [FPP_W-1:0] fpp_reg = FPP_RESET;

  victim_t pending_victims [$];
  int      mismatch_count = 0;
  int      idle_cycles = 0;
  int      burst_left = 0;

  function automatic bit sweep_pass(input int base, input int n, input int start,
                                    input mod_sel_t sel, input bit clr, output int hit);
    int k;
    int idx;
    bit mod_ok;
    hit = 0;
    for (k = 0; k < n; k++) begin
      idx = base + (start + k) % n;
      mod_ok = (sel == MOD_ANY) || (dirty_f[idx] == (sel == MOD_ONE));
      if (res_f[idx] && !use_f[idx] && mod_ok) begin
        hit = (start + k) % n;
        return 1'b1;
      end
      if (clr) use_f[idx] = 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic victim_t choose_victim(input page_op_t op);
    victim_t r;
    int n;
    int base;
    int start;
    int hit;
    bit found;
    r = NONE;
    base = int'(op.pid) * NFRM;
    if (op.cmd == CMD_UPDATE) begin
      use_f[base + int'(op.slot)] = op.use_b;
      dirty_f[base + int'(op.slot)] = op.mod_b;
      res_f[base + int'(op.slot)] = op.pres_b;
      return r;
    end
    n = (int'(fpp_reg) > NFRM) ? NFRM : int'(fpp_reg);
    if (n == 0) return r;
    start = hands[op.pid] % n;
    if (mode_reg == CLOCK) begin
      found = sweep_pass(base, n, start, MOD_ANY, 1'b1, hit);
      if (!found) found = sweep_pass(base, n, start, MOD_ANY, 1'b1, hit);
    end else begin
      found = sweep_pass(base, n, start, MOD_ZERO, 1'b0, hit);
      if (!found) found = sweep_pass(base, n, start, MOD_ONE, 1'b1, hit);
      if (!found) found = sweep_pass(base, n, start, MOD_ANY, 1'b1, hit);
      if (!found) found = sweep_pass(base, n, start, MOD_ONE, 1'b1, hit);
    end
    if (found) begin
      hands[op.pid] = hit;
      r.slot = SLOT_W'(hit);
      r.found = 1'b1;
    end
    return r;
  endfunction

  // receiver stall pattern
  logic [7:0] rx_cnt = '0;
  logic [1:0] rx_mode = '0;
  always @(posedge clk) begin
    rx_cnt <= rx_cnt + 8'd1;
    if (rx_cnt[5:0] == 6'd0) rx_mode <= 2'($urandom_range(0, 2));
    case (rx_mode)
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= (rx_cnt[2:0] == 3'd0);
    endcase
  end

  // result checker and watchdog
  always @(posedge clk) begin
    victim_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_victims.size() == 0) begin
        $display("%0t: unexpected result slot %0d found %0b", $time,
                 out_tdata[SLOT_W-1:0], out_tuser);
        mismatch_count++;
      end else begin
        want = pending_victims.pop_front();
        if (out_tdata[SLOT_W-1:0] !== want.slot || out_tuser !== want.found) begin
          $display("%0t: expected slot %0d found %0b, actual slot %0d found %0b", $time,
                   want.slot, want.found, out_tdata[SLOT_W-1:0], out_tuser);
          mismatch_count++;
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pwrite))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL clock_page_replacement");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic send_item(input page_op_t op, input logic typed, input victim_t want);
    victim_t pred;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op.cmd;
    in_tdata <= {{(IN_DW-11){1'b0}}, op.pres_b, op.mod_b, op.use_b, op.slot, op.pid};
    do @(posedge clk); while (!in_tready);
    pred = choose_victim(op);
    pending_victims.push_back(typed ? want : pred);
    burst_left--;
  endtask

  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (pending_victims.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic reg_sel, input logic [CFG_DW-1:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {reg_sel, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (reg_sel == REG_MODE) mode_reg = value[0];
    else fpp_reg = value[FPP_W-1:0];
    @(posedge clk);
  endtask

  task automatic run_phase(input logic mode, input int frames, input int count);
    page_op_t op;
    int n;
    cfg_write(REG_MODE, CFG_DW'(mode));
    cfg_write(REG_FRAMES, CFG_DW'(frames));
    n = (frames > NFRM) ? NFRM : frames;
    for (int i = 0; i < count; i++) begin
      op.cmd = ($urandom_range(0, 99) < 55) ? CMD_UPDATE : CMD_VICTIM;
      op.pid = ($urandom_range(0, 99) < 70) ? PID_W'($urandom_range(0, 3))
                                              : PID_W'($urandom_range(0, NPROC-1));
      op.slot = (n > 0 && $urandom_range(0, 99) < 70) ? SLOT_W'($urandom_range(0, n-1))
                                                       : SLOT_W'($urandom_range(0, NFRM-1));
      op.use_b = 1'($urandom_range(0, 1));
      op.mod_b = 1'($urandom_range(0, 1));
      op.pres_b = ($urandom_range(0, 99) < 75);
      send_item(op, 1'b0, NONE);
      if (i == count / 2 && mode == CLOCK_M && frames == NFRM) wait_results();
    end
    wait_results();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);

    foreach (OP_TABLE[i]) send_item(OP_TABLE[i].op, OP_TABLE[i].typed, OP_TABLE[i].want);
    wait_results();

    run_phase(CLOCK_M, 16, 120);
    run_phase(CLOCK, 16, 80);
    run_phase(CLOCK, 5, 80);
    run_phase(CLOCK_M, 7, 80);
    run_phase(CLOCK, 1, 40);
    run_phase(CLOCK_M, 1, 40);
    run_phase(CLOCK, 0, 20);
    run_phase(CLOCK_M, 0, 20);
    run_phase(CLOCK_M, 31, 60);
    run_phase(CLOCK, 17, 60);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_victims.size() == 0)
      $display("PASS clock_page_replacement");
    else
      $display("FAIL clock_page_replacement");
    $finish;
  end

endmodule
